[sv/mpfs_pkg.sv]
package mpfs_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 2048;
  localparam int unsigned MIN_FRAME_BYTES = 12;
  localparam int unsigned HDR_BYTES       = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned PRIO_W = 11;
  localparam int unsigned SDT_W  = 8;
  localparam int unsigned LEN_W  = 12;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned ADDR_W = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_DATA      = 3'd0,
    ST_NOT_XL    = 3'd1,
    ST_UNPADDED  = 3'd2,
    ST_TOO_SHORT = 3'd3,
    ST_OVERRUN   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HDR0 = 2'd1,
    PH_HDR1 = 2'd2,
    PH_DATA = 2'd3
  } phase_e;

  typedef enum logic {
    REG_PRIO = 1'b0,
    REG_SDT  = 1'b1
  } reg_e;

  typedef struct packed {
    status_e            status;
    logic [SDT_W-1:0]   sdt;
    logic [LEN_W-1:0]   len;
    logic [WORD_W-1:0]  acceptance;
    logic [WORD_W-1:0]  word;
    logic               last;
  } res_t;

endpackage

[sv/mpfs_if.sv]
interface mpfs_in_if;
  logic                          valid;
  logic                          ready;
  logic [mpfs_pkg::WORD_W-1:0]   data_word;
  logic                          first_word;
  logic                          frame_xl;
  logic [mpfs_pkg::SDT_W-1:0]    frame_sdt;
  logic [mpfs_pkg::LEN_W-1:0]    frame_len;

  modport source (output valid, data_word, first_word, frame_xl, frame_sdt, frame_len,
                  input ready);
  modport sink (input valid, data_word, first_word, frame_xl, frame_sdt, frame_len,
                output ready);
endinterface

interface mpfs_out_if;
  logic                          valid;
  logic                          ready;
  logic [mpfs_pkg::STAT_W-1:0]   status;
  logic [mpfs_pkg::PRIO_W-1:0]   out_priority;
  logic [mpfs_pkg::SDT_W-1:0]    out_sdt;
  logic [mpfs_pkg::LEN_W-1:0]    out_len;
  logic [mpfs_pkg::WORD_W-1:0]   out_acceptance;
  logic [mpfs_pkg::WORD_W-1:0]   out_word;
  logic                          last_of_pdu;

  modport source (output valid, status, out_priority, out_sdt, out_len, out_acceptance,
                  out_word, last_of_pdu, input ready);
  modport sink (input valid, status, out_priority, out_sdt, out_len, out_acceptance,
                out_word, last_of_pdu, output ready);
endinterface

[sv/mpfs_front.sv]
module mpfs_front #(
  parameter int unsigned MaxFrameBytes = mpfs_pkg::MAX_FRAME_BYTES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mpfs_in_if.sink                    in_i,
  input  logic [mpfs_pkg::SDT_W-1:0] cfg_sdt_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output mpfs_pkg::res_t             q_data_o
);

  localparam int unsigned BLW = $clog2(MaxFrameBytes + 1);
  localparam int unsigned WW  = BLW - 2;

  mpfs_pkg::phase_e phase_q, phase_d, cur_phase;
  logic [BLW-1:0]   bytes_q, bytes_d, cur_bytes, bytes_after;
  logic [WW-1:0]    words_q, words_d;
  logic [7:0]       type_q, type_d;
  logic [BLW-1:0]   len_q, len_d;
  logic [31:0]      id_q, id_d;

  logic             fire;
  logic             sdt_ok, pad_err, short_err, first_ok;
  logic [15:0]      plen;
  logic [17:0]      pad, need;
  logic             overrun, hdr_stop;

  assign in_i.ready = !q_full_i;
  assign fire       = in_i.valid && in_i.ready;

  assign sdt_ok    = in_i.frame_sdt == cfg_sdt_i;
  assign pad_err   = (in_i.frame_len[1:0] != 2'b00)
                  || (in_i.frame_len > mpfs_pkg::LEN_W'(MaxFrameBytes));
  assign short_err = in_i.frame_len < mpfs_pkg::LEN_W'(mpfs_pkg::MIN_FRAME_BYTES);
  assign first_ok  = in_i.first_word && in_i.frame_xl && sdt_ok && !pad_err && !short_err;

  assign cur_phase = in_i.first_word ? (first_ok ? mpfs_pkg::PH_HDR0 : mpfs_pkg::PH_IDLE)
                                     : phase_q;
  assign cur_bytes = first_ok ? BLW'(in_i.frame_len) : bytes_q;
  assign bytes_after = (cur_bytes >= BLW'(4)) ? cur_bytes - BLW'(4) : '0;

  assign plen     = in_i.data_word[15:0];
  assign pad      = ({2'b00, plen} + 18'd3) & ~18'd3;
  assign need     = pad + 18'(mpfs_pkg::HDR_BYTES);
  assign overrun  = need > 18'(cur_bytes);
  assign hdr_stop = (cur_bytes < BLW'(mpfs_pkg::MIN_FRAME_BYTES)) || (plen == 16'd0);

  // next state
  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      case (cur_phase)
        mpfs_pkg::PH_HDR0: begin
          phase_d = (hdr_stop || overrun) ? mpfs_pkg::PH_IDLE : mpfs_pkg::PH_HDR1;
        end
        mpfs_pkg::PH_HDR1: begin
          phase_d = (words_q != '0) ? mpfs_pkg::PH_DATA : mpfs_pkg::PH_HDR0;
        end
        mpfs_pkg::PH_DATA: begin
          phase_d = (words_q <= WW'(1)) ? mpfs_pkg::PH_HDR0 : mpfs_pkg::PH_DATA;
        end
        default: phase_d = mpfs_pkg::PH_IDLE;
      endcase
    end
  end

  // outputs and datapath
  always_comb begin
    q_push_o = 1'b0;
    q_data_o = '0;
    bytes_d  = bytes_q;
    words_d  = words_q;
    type_d   = type_q;
    len_d    = len_q;
    id_d     = id_q;
    if (fire) begin
      if (in_i.first_word && !first_ok) begin
        if (!in_i.frame_xl) begin
          q_push_o        = 1'b1;
          q_data_o.status = mpfs_pkg::ST_NOT_XL;
        end else if (sdt_ok) begin
          q_push_o        = 1'b1;
          q_data_o.status = pad_err ? mpfs_pkg::ST_UNPADDED : mpfs_pkg::ST_TOO_SHORT;
        end
      end else begin
        case (cur_phase)
          mpfs_pkg::PH_HDR0: begin
            if (!hdr_stop) begin
              if (overrun) begin
                q_push_o        = 1'b1;
                q_data_o.status = mpfs_pkg::ST_OVERRUN;
              end else begin
                type_d  = in_i.data_word[31:24];
                len_d   = plen[BLW-1:0];
                words_d = pad[WW+1:2];
                bytes_d = bytes_after;
              end
            end
          end
          mpfs_pkg::PH_HDR1: begin
            id_d    = in_i.data_word;
            bytes_d = bytes_after;
          end
          mpfs_pkg::PH_DATA: begin
            q_push_o            = 1'b1;
            q_data_o.status     = mpfs_pkg::ST_DATA;
            q_data_o.sdt        = type_q;
            q_data_o.len        = mpfs_pkg::LEN_W'(len_q);
            q_data_o.acceptance = id_q;
            q_data_o.word       = in_i.data_word;
            q_data_o.last       = words_q == WW'(1);
            words_d             = (words_q != '0) ? words_q - WW'(1) : '0;
            bytes_d             = bytes_after;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mpfs_pkg::PH_IDLE;
      bytes_q <= '0;
      words_q <= '0;
    end else begin
      phase_q <= phase_d;
      bytes_q <= bytes_d;
      words_q <= words_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    len_q  <= len_d;
    id_q   <= id_d;
  end

  a_push_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> fire) else $error("push without accepted transaction");

  a_error_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && q_data_o.status != mpfs_pkg::ST_DATA) |=> phase_q == mpfs_pkg::PH_IDLE)
    else $error("error result did not end the frame");

  a_data_has_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mpfs_pkg::PH_DATA |-> words_q != '0)
    else $error("data phase with no words left");

endmodule

[sv/mpfs_queue.sv]
module mpfs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mpfs_pkg::res_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mpfs_pkg::res_t data_o
);

  localparam int unsigned DEPTH = mpfs_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  mpfs_pkg::res_t mem_q [DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue overflow");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("queue count did not advance");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

[sv/mpfs_back.sv]
module mpfs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  mpfs_pkg::res_t              q_data_i,
  output logic                        q_pop_o,
  input  logic [mpfs_pkg::PRIO_W-1:0] prio_i,
  mpfs_out_if.source                  out_o
);

  logic                        valid_q, valid_d;
  mpfs_pkg::res_t              res_q;
  logic [mpfs_pkg::PRIO_W-1:0] prio_q;
  logic                        load;

  assign load    = q_valid_i && (!valid_q || out_o.ready);
  assign q_pop_o = load;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= q_data_i;
      prio_q <= prio_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.status         = res_q.status;
  assign out_o.out_priority   = prio_q;
  assign out_o.out_sdt        = res_q.sdt;
  assign out_o.out_len        = res_q.len;
  assign out_o.out_acceptance = res_q.acceptance;
  assign out_o.out_word       = res_q.word;
  assign out_o.last_of_pdu    = res_q.last;

  a_pop_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> valid_q) else $error("popped transaction not shown");

  a_error_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.status != mpfs_pkg::ST_DATA) |-> (res_q.word == '0 && !res_q.last))
    else $error("error result carries data");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i) else $error("pop from empty queue");

endmodule

[sv/multi_pdu_frame_splitter_unit.sv]
// Splits CAN XL multi-PDU frames, given as 32-bit payload words, into the data words of the
// contained PDUs. One input word is accepted every clock cycle as long as the two-entry result
// queue has room; a result is registered in the result queue and then in the output register;
// the output keeps up one result per cycle while the sink takes them. Header words and dropped
// words give no result. Error results carry only status and priority.
// Registers: 0x0 transfer priority (11 bits), 0x4 multi-PDU SDT (8 bits); write them only
// while no frame is in flight.
module multi_pdu_frame_splitter_unit #(
  parameter int unsigned MaxFrameBytes = mpfs_pkg::MAX_FRAME_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mpfs_in_if.sink                     in_i,
  mpfs_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mpfs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [mpfs_pkg::PRIO_W-1:0] prio_q, prio_d;
  logic [mpfs_pkg::SDT_W-1:0]  sdt_q, sdt_d;
  logic                        wr_en;
  mpfs_pkg::reg_e              reg_sel;

  logic                        q_push, q_full, q_valid, q_pop;
  mpfs_pkg::res_t              q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = mpfs_pkg::reg_e'(paddr[2]);

  always_comb begin
    prio_d = prio_q;
    sdt_d  = sdt_q;
    if (wr_en) begin
      case (reg_sel)
        mpfs_pkg::REG_PRIO: prio_d = pwdata[mpfs_pkg::PRIO_W-1:0];
        mpfs_pkg::REG_SDT:  sdt_d  = pwdata[mpfs_pkg::SDT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mpfs_pkg::REG_PRIO: prdata = 32'(prio_q);
      mpfs_pkg::REG_SDT:  prdata = 32'(sdt_q);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q <= '0;
      sdt_q  <= '0;
    end else begin
      prio_q <= prio_d;
      sdt_q  <= sdt_d;
    end
  end

  mpfs_front #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_sdt_i(sdt_q),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  mpfs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  mpfs_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_data_i (q_rdata),
    .q_pop_o  (q_pop),
    .prio_i   (prio_q),
    .out_o    (out_o)
  );

endmodule

[tb/multi_pdu_frame_splitter_unit_tb.sv]
`timescale 1ns / 1ps

module multi_pdu_frame_splitter_unit_tb;
  import mpfs_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 8;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic              first;
    logic              xl;
    logic [SDT_W-1:0]  sdt;
    logic [LEN_W-1:0]  len;
  } frame_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PRIO_W-1:0] prio;
    logic [SDT_W-1:0]  sdt;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] word;
    logic              last;
  } pdu_result_t;

  class pdu_split_scoreboard;
    logic [PRIO_W-1:0] cfg_prio = '0;
    logic [SDT_W-1:0]  cfg_sdt  = '0;
    phase_e            phase    = PH_IDLE;
    int unsigned       bytes_left = 0;
    logic [9:0]        words_left = '0;
    logic [7:0]        held_type  = '0;
    logic [15:0]       held_len   = '0;
    logic [31:0]       held_id    = '0;
    pdu_result_t       due_results[$];
    int unsigned       mismatches = 0;
    int unsigned       checked    = 0;

    function void set_config(reg_e r, logic [31:0] value);
      case (r)
        REG_PRIO: cfg_prio = value[PRIO_W-1:0];
        REG_SDT:  cfg_sdt  = value[SDT_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_error(status_e s);
      pdu_result_t r;
      r = '0;
      r.status = s;
      r.prio = cfg_prio;
      due_results.push_back(r);
      phase = PH_IDLE;
    endfunction

    function void consume_word();
      bytes_left = (bytes_left >= 4) ? bytes_left - 4 : 0;
    endfunction

    // works out the result, if any, of one accepted payload word
    function void split_word(frame_word_t w);
      int unsigned plen;
      int unsigned pad;
      pdu_result_t r;
      if (w.first) begin
        phase = PH_IDLE;
        if (!w.xl) begin
          push_error(ST_NOT_XL);
          return;
        end
        if (w.sdt != cfg_sdt) return;
        if (w.len[1:0] != 2'b00 || w.len > MAX_FRAME_BYTES) begin
          push_error(ST_UNPADDED);
          return;
        end
        if (w.len < MIN_FRAME_BYTES) begin
          push_error(ST_TOO_SHORT);
          return;
        end
        bytes_left = w.len;
        phase = PH_HDR0;
      end
      case (phase)
        PH_HDR0: begin
          if (bytes_left < MIN_FRAME_BYTES) begin
            phase = PH_IDLE;
            return;
          end
          plen = w.data[15:0];
          if (plen == 0) begin
            phase = PH_IDLE;
            return;
          end
          pad = (plen + 3) & ~32'd3;
          if (HDR_BYTES + pad > bytes_left) begin
            push_error(ST_OVERRUN);
            return;
          end
          held_type = w.data[31:24];
          held_len = plen[15:0];
          words_left = pad[11:2];
          consume_word();
          phase = PH_HDR1;
        end
        PH_HDR1: begin
          held_id = w.data;
          consume_word();
          phase = (words_left != 0) ? PH_DATA : PH_HDR0;
        end
        PH_DATA: begin
          r.status = ST_DATA;
          r.prio = cfg_prio;
          r.sdt = held_type;
          r.len = held_len[LEN_W-1:0];
          r.acc = held_id;
          r.word = w.data;
          r.last = (words_left == 1);
          due_results.push_back(r);
          if (words_left > 0) words_left--;
          consume_word();
          if (words_left == 0) phase = PH_HDR0;
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    function string show(pdu_result_t r);
      return $sformatf("st=%0d prio=%h sdt=%h len=%0d acc=%h word=%h last=%b",
                       r.status, r.prio, r.sdt, r.len, r.acc, r.word, r.last);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 30) $display("mismatch: %s", msg);
    endtask

    task check_result(pdu_result_t got);
      pdu_result_t exp;
      if (due_results.size() == 0) begin
        report_mismatch({"unexpected result ", show(got)});
        return;
      end
      exp = due_results.pop_front();
      checked++;
      if (got.status !== exp.status || got.prio !== exp.prio || got.sdt !== exp.sdt ||
          got.len !== exp.len || got.acc !== exp.acc || got.word !== exp.word ||
          got.last !== exp.last) begin
        report_mismatch($sformatf("result %0d expected %s got %s", checked, show(exp),
                                  show(got)));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  mpfs_in_if  in_if ();
  mpfs_out_if out_if ();

  multi_pdu_frame_splitter_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pdu_split_scoreboard sb = new();
  frame_word_t frame_q[$];
  int unsigned items_sent = 0;
  bit src_gaps = 1'b1;
  bit snk_gaps = 1'b1;
  bit hold_off_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("multi_pdu_frame_splitter_unit_tb: done, errors");
    $finish;
  end

  // result sink with random stalls and one long hold-off
  initial begin
    int gap;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      gap = snk_gaps ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  always @(posedge clk_i) begin : monitor
    frame_word_t w;
    pdu_result_t r;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        w.data = in_if.data_word;
        w.first = in_if.first_word;
        w.xl = in_if.frame_xl;
        w.sdt = in_if.frame_sdt;
        w.len = in_if.frame_len;
        sb.split_word(w);
      end
      if (out_if.valid && out_if.ready) begin
        r.status = out_if.status;
        r.prio = out_if.out_priority;
        r.sdt = out_if.out_sdt;
        r.len = out_if.out_len;
        r.acc = out_if.out_acceptance;
        r.word = out_if.out_word;
        r.last = out_if.last_of_pdu;
        sb.check_result(r);
      end
    end
  end

  task automatic write_reg(reg_e r, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(r) << 2;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_config(r, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_word(frame_word_t w);
    int gap;
    gap = src_gaps ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.data_word <= w.data;
    in_if.first_word <= w.first;
    in_if.frame_xl <= w.xl;
    in_if.frame_sdt <= w.sdt;
    in_if.frame_len <= w.len;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_word(frame_q[i]);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic frame_word_t mk_word(logic [31:0] data, logic first, logic xl,
                                          logic [7:0] sdt, logic [11:0] len);
    frame_word_t w;
    w.data = data;
    w.first = first;
    w.xl = xl;
    w.sdt = sdt;
    w.len = len;
    return w;
  endfunction

  // frame side fields only count on a first word, so they are noise elsewhere
  function automatic frame_word_t rand_word();
    return mk_word($urandom, 1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   12'($urandom_range(0, MAX_FRAME_BYTES)));
  endfunction

  function automatic frame_word_t hdr_word(int unsigned plen);
    frame_word_t w;
    w = rand_word();
    w.data[15:0] = plen[15:0];
    return w;
  endfunction

  // chain of pdus filling nwords words, optionally with one overrunning header
  function automatic void build_frame(logic [7:0] sdt, int unsigned nwords, bit overrun);
    int unsigned r;
    int unsigned pdu;
    int unsigned bad_at;
    int unsigned plen;
    int unsigned lim;
    r = nwords * 4;
    pdu = 0;
    bad_at = $urandom_range(0, 2);
    frame_q.delete();
    while (r >= MIN_FRAME_BYTES) begin
      if (overrun && pdu == bad_at) begin
        frame_q.push_back(hdr_word($urandom_range(r - 7, 16'hFFFF)));
        break;
      end
      if ($urandom_range(0, 15) == 0) begin
        frame_q.push_back(hdr_word(0));
        break;
      end
      lim = r - HDR_BYTES;
      plen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, lim)
                                         : $urandom_range(1, (lim < 16) ? lim : 16);
      frame_q.push_back(hdr_word(plen));
      frame_q.push_back(rand_word());
      repeat ((plen + 3) / 4) frame_q.push_back(rand_word());
      r -= HDR_BYTES + ((plen + 3) & ~32'd3);
      pdu++;
    end
    while (frame_q.size() < nwords) frame_q.push_back(rand_word());
    frame_q[0].first = 1'b1;
    frame_q[0].xl = 1'b1;
    frame_q[0].sdt = sdt;
    frame_q[0].len = 12'(nwords * 4);
  endfunction

  task automatic directed_items();
    frame_q.delete();
    frame_q.push_back(mk_word(32'h0000_0000, 1'b0, 1'b1, 8'h00, 12'd12));
    // not xl, then a trailing word
    frame_q.push_back(mk_word(32'h0000_0004, 1'b1, 1'b0, 8'h00, 12'd12));
    frame_q.push_back(mk_word(32'hFFFF_FFFF, 1'b0, 1'b1, 8'h00, 12'd12));
    // foreign sdt
    frame_q.push_back(mk_word(32'h0000_0004, 1'b1, 1'b1, 8'hFF, 12'd12));
    frame_q.push_back(mk_word(32'h1234_5678, 1'b0, 1'b0, 8'hFF, 12'd0));
    frame_q.push_back(mk_word(32'h0000_0004, 1'b1, 1'b1, 8'h00, 12'd13));
    frame_q.push_back(mk_word(32'h0000_0004, 1'b1, 1'b1, 8'h00, 12'd8));
    // smallest frame with one pdu
    frame_q.push_back(mk_word(32'hFF00_0004, 1'b1, 1'b1, 8'h00, 12'd12));
    frame_q.push_back(mk_word(32'hFFFF_FFFF, 1'b0, 1'b1, 8'hFF, 12'd2048));
    frame_q.push_back(mk_word(32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00, 12'd0));
    // one byte pdu, then too few bytes left for another header
    frame_q.push_back(mk_word(32'h00FF_0001, 1'b1, 1'b1, 8'h00, 12'd20));
    frame_q.push_back(mk_word(32'h0000_0000, 1'b0, 1'b0, 8'h00, 12'd0));
    frame_q.push_back(mk_word(32'h0000_0000, 1'b0, 1'b0, 8'h00, 12'd0));
    frame_q.push_back(mk_word(32'h0000_0004, 1'b0, 1'b0, 8'h00, 12'd0));
    frame_q.push_back(mk_word(32'hA5A5_A5A5, 1'b0, 1'b0, 8'h00, 12'd0));
    // zero length pdu ends parsing
    frame_q.push_back(mk_word(32'h0100_0000, 1'b1, 1'b1, 8'h00, 12'd12));
    frame_q.push_back(mk_word(32'h0000_0004, 1'b0, 1'b1, 8'h00, 12'd12));
    frame_q.push_back(mk_word(32'h5A5A_5A5A, 1'b0, 1'b1, 8'h00, 12'd12));
    // pdu longer than the frame
    frame_q.push_back(mk_word(32'h0200_0005, 1'b1, 1'b1, 8'h00, 12'd12));
    frame_q.push_back(mk_word(32'h0000_0001, 1'b0, 1'b1, 8'h00, 12'd12));
    frame_q.push_back(mk_word(32'h0000_0002, 1'b0, 1'b1, 8'h00, 12'd12));
    send_frame();
  endtask

  task automatic random_items(int unsigned target, bit big, bit squeeze);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned nwords;
    int unsigned cut;
    stop_at = items_sent + target;
    if (squeeze) begin
      hold_off_req = 1'b1;
      build_frame(sb.cfg_sdt, 64, 1'b0);
      send_frame();
    end
    if (big) begin
      build_frame(sb.cfg_sdt, MAX_FRAME_BYTES / 4, 1'b0);
      send_frame();
    end
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      nwords = ($urandom_range(0, 9) < 8) ? $urandom_range(3, 16) : $urandom_range(17, 64);
      build_frame(sb.cfg_sdt, nwords, kind >= 70 && kind < 74);
      if (kind >= 74 && kind < 80) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end else if (kind >= 80 && kind < 84) begin
        frame_q[0].xl = 1'b0;
        frame_q[0].sdt = 8'($urandom_range(0, 255));
      end else if (kind >= 84 && kind < 88) begin
        frame_q[0].sdt = sb.cfg_sdt ^ 8'($urandom_range(1, 255));
      end else if (kind >= 88 && kind < 92) begin
        frame_q[0].len = 12'(4 * $urandom_range(0, 511) + $urandom_range(1, 3));
      end else if (kind >= 92 && kind < 96) begin
        frame_q[0].len = 12'($urandom_range(0, MIN_FRAME_BYTES - 1));
      end else if (kind >= 96) begin
        frame_q.delete();
        repeat ($urandom_range(1, 4)) frame_q.push_back(rand_word());
      end
      send_frame();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.data_word = '0;
    in_if.first_word = 1'b0;
    in_if.frame_xl = 1'b0;
    in_if.frame_sdt = '0;
    in_if.frame_len = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_items();
    settle();

    write_reg(REG_PRIO, 32'h0000_07FF);
    write_reg(REG_SDT, 32'h0000_00FF);
    random_items(400, 1'b0, 1'b0);
    settle();

    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    write_reg(REG_PRIO, 32'h0000_0000);
    write_reg(REG_SDT, 32'h0000_0000);
    random_items(400, 1'b1, 1'b0);
    settle();

    snk_gaps = 1'b1;
    write_reg(REG_PRIO, $urandom);
    write_reg(REG_SDT, $urandom);
    random_items(400, 1'b0, 1'b1);
    settle();

    src_gaps = 1'b1;
    snk_gaps = $urandom_range(0, 1);
    write_reg(REG_PRIO, $urandom_range(1, 2046));
    write_reg(REG_SDT, $urandom_range(1, 254));
    random_items(400, 1'b0, 1'b0);
    settle();

    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("multi_pdu_frame_splitter_unit_tb: done, clean");
    end else begin
      $display("multi_pdu_frame_splitter_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
